// ===== hdl/gcgs_pkg.sv =====
// Shared types, constants and helper functions for the great-circle grid spacing block.
// No dependencies; every other file imports it.
package gcgs_pkg;

	localparam int ANGLE_FRAC_BITS = 28;
	localparam int CORDIC_STEPS    = 28;
	localparam int Q_SHIFT         = 30 - ANGLE_FRAC_BITS;
	localparam int CW              = 36;   // CORDIC register width
	localparam int SQW             = 61;   // square root working width
	localparam int RADIUS_W        = 27;
	localparam int SPACING_W       = 40;
	localparam int STEP_W          = 5;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
	localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(30);

	localparam logic signed [CW-1:0] Q30_ONE         = CW'(64'sd1073741824);
	localparam logic signed [CW-1:0] Q30_HALF_PI     = CW'(64'sd1686629713);
	localparam logic signed [CW-1:0] Q30_PI          = CW'(64'sd3373259426);
	localparam logic signed [CW-1:0] Q30_TWO_PI      = CW'(64'sd6746518852);
	localparam logic signed [CW-1:0] CORDIC_GAIN_INV = CW'(64'sd652032874);
	localparam logic [RADIUS_W-1:0]  RADIUS_RESET    = RADIUS_W'(6371229);

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_LOAD_DLON, OP_REDUCE, OP_FOLD, OP_ROT, OP_CAP_LAT,
		OP_CAP_DLON, OP_MUL_A, OP_MUL_B, OP_MUL_C, OP_ARG, OP_MUL_D, OP_SQ_INIT,
		OP_SQ, OP_VEC_INIT, OP_VEC, OP_SEG, OP_EMIT_PAIR, OP_EMIT_END,
		OP_EMIT_SINGLE, OP_COMMIT
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [STEP_W-1:0] step;
		logic              first_pair; // second point of the line
		logic              pair_line;  // a segment exists for this point
	} cmd_t;

	typedef struct packed {
		logic reduced;
		logic eol;
		logic out_free;
	} status_t;

	function automatic logic signed [CW-1:0] atan_q30(input logic [STEP_W-1:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:  v = 32'h3243F6A8; 5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC; 5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76; 5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA; 5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA; 5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF; 5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF; 5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF; 5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF; 5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF; 5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF; 5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF; 5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F; 5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F; 5'd27: v = 32'h00000007;
			5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return signed'(CW'(v));
	endfunction

	// Round v / 2^s to nearest, ties away from zero.
	function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
		logic signed [63:0] half;
		half = 64'sd1 <<< (s - 1);
		if (v >= 0)
			return (v + half) >>> s;
		else
			return -((-v + half) >>> s);
	endfunction

endpackage

// ===== hdl/gcgs_ctrl.sv =====
// Sequencer for the grid spacing block: walks each point through the CORDIC,
// multiply and square root steps of the datapath. Depends on gcgs_pkg.
module gcgs_ctrl import gcgs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_RED_LAT, S_FOLD_LAT, S_ROT_LAT, S_CAP_LAT, S_LD_DL, S_RED_DL,
		S_FOLD_DL, S_ROT_DL, S_CAP_DL, S_MUL_A, S_MUL_B, S_MUL_C, S_ARG, S_MUL_D,
		S_SQ_INIT, S_SQ, S_VEC_INIT, S_VEC, S_SEG, S_EMIT_PAIR, S_EMIT_END,
		S_EMIT_SINGLE, S_COMMIT
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic [1:0]        pts_q;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd.step       = step_q;
		cmd.first_pair = (pts_q == 2'd1);
		cmd.pair_line  = (pts_q != 2'd0);
		unique case (state_q)
			S_IDLE:        cmd.op = OP_LOAD;
			S_RED_LAT, S_RED_DL: cmd.op = OP_REDUCE;
			S_FOLD_LAT, S_FOLD_DL: cmd.op = OP_FOLD;
			S_ROT_LAT, S_ROT_DL: cmd.op = OP_ROT;
			S_CAP_LAT:     cmd.op = OP_CAP_LAT;
			S_LD_DL:       cmd.op = OP_LOAD_DLON;
			S_CAP_DL:      cmd.op = OP_CAP_DLON;
			S_MUL_A:       cmd.op = OP_MUL_A;
			S_MUL_B:       cmd.op = OP_MUL_B;
			S_MUL_C:       cmd.op = OP_MUL_C;
			S_ARG:         cmd.op = OP_ARG;
			S_MUL_D:       cmd.op = OP_MUL_D;
			S_SQ_INIT:     cmd.op = OP_SQ_INIT;
			S_SQ:          cmd.op = OP_SQ;
			S_VEC_INIT:    cmd.op = OP_VEC_INIT;
			S_VEC:         cmd.op = OP_VEC;
			S_SEG:         cmd.op = OP_SEG;
			S_EMIT_PAIR:   cmd.op = status.out_free ? OP_EMIT_PAIR : OP_NONE;
			S_EMIT_END:    cmd.op = status.out_free ? OP_EMIT_END : OP_NONE;
			S_EMIT_SINGLE: cmd.op = status.out_free ? OP_EMIT_SINGLE : OP_NONE;
			S_COMMIT:      cmd.op = OP_COMMIT;
			default:       cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			pts_q   <= 2'd0;
		end else begin
			unique case (state_q)
				S_IDLE: if (s_tvalid) state_q <= S_RED_LAT;
				S_RED_LAT: if (status.reduced) state_q <= S_FOLD_LAT;
				S_FOLD_LAT: begin
					step_q  <= '0;
					state_q <= S_ROT_LAT;
				end
				S_ROT_LAT: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) state_q <= S_CAP_LAT;
				end
				S_CAP_LAT: begin
					if (pts_q != 2'd0)
						state_q <= S_LD_DL;
					else if (status.eol)
						state_q <= S_EMIT_SINGLE;
					else
						state_q <= S_COMMIT;
				end
				S_LD_DL: state_q <= S_RED_DL;
				S_RED_DL: if (status.reduced) state_q <= S_FOLD_DL;
				S_FOLD_DL: begin
					step_q  <= '0;
					state_q <= S_ROT_DL;
				end
				S_ROT_DL: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) state_q <= S_CAP_DL;
				end
				S_CAP_DL: state_q <= S_MUL_A;
				S_MUL_A:  state_q <= S_MUL_B;
				S_MUL_B:  state_q <= S_MUL_C;
				S_MUL_C:  state_q <= S_ARG;
				S_ARG:    state_q <= S_MUL_D;
				S_MUL_D:  state_q <= S_SQ_INIT;
				S_SQ_INIT: begin
					step_q  <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					step_q <= step_q + 1'b1;
					if (step_q == SQRT_LAST) state_q <= S_VEC_INIT;
				end
				S_VEC_INIT: begin
					step_q  <= '0;
					state_q <= S_VEC;
				end
				S_VEC: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) state_q <= S_SEG;
				end
				S_SEG: state_q <= S_EMIT_PAIR;
				S_EMIT_PAIR: if (status.out_free)
					state_q <= status.eol ? S_EMIT_END : S_COMMIT;
				S_EMIT_END: if (status.out_free) state_q <= S_COMMIT;
				S_EMIT_SINGLE: if (status.out_free) state_q <= S_COMMIT;
				S_COMMIT: begin
					if (status.eol)
						pts_q <= 2'd0;
					else
						pts_q <= (pts_q == 2'd0) ? 2'd1 : 2'd2;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/gcgs_dp.sv =====
// Datapath of the grid spacing block: shared CORDIC unit, multiplier, bit-serial
// square root, point history and result register. Depends on gcgs_pkg.
module gcgs_dp import gcgs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output status_t                status,
	input  logic                   s_tvalid,
	input  logic [63:0]            s_tdata,
	input  logic                   s_tlast,
	input  logic                   cfg_valid,
	input  logic [RADIUS_W-1:0]    cfg_data,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [SPACING_W-1:0]   m_tdata,
	output logic                   m_tuser,
	output logic                   m_tlast
);

	logic [RADIUS_W-1:0]    radius_q;
	logic signed [31:0]     lon_q, prior_lon_q;
	logic                   eol_q;
	logic signed [29:0]     cur_s_q, cur_c_q, prior_s_q, prior_c_q;
	logic signed [31:0]     cd_q, cc_q, ss_q;
	logic signed [CW-1:0]   x_q, y_q, z_q, carg_q;
	logic                   flip_q;
	logic signed [63:0]     p_q;
	logic [SQW-1:0]         sq_v_q, sq_r_q, sq_bit_q;
	logic [31:0]            seg_q, prior_seg_q;

	logic signed [CW-1:0]   xs, ys, atn, wrap, x_out, argsum;
	logic [SQW-1:0]         sq_try;
	logic [33:0]            sum;
	logic [60:0]            prod;
	logic [37:0]            scaled;
	logic [SPACING_W-1:0]   spc;
	logic                   emit_op;

	assign xs     = x_q >>> cmd.step;
	assign ys     = y_q >>> cmd.step;
	assign atn    = atan_q30(cmd.step);
	assign x_out  = flip_q ? -x_q : x_q;
	assign sq_try = sq_r_q + sq_bit_q;
	assign argsum = CW'(ss_q) + CW'(rnd(p_q, 30));
	assign emit_op = (cmd.op == OP_EMIT_PAIR) || (cmd.op == OP_EMIT_END)
		|| (cmd.op == OP_EMIT_SINGLE);

	always_comb begin
		if (z_q > Q30_PI)
			wrap = z_q - Q30_TWO_PI;
		else if (z_q < -Q30_PI)
			wrap = z_q + Q30_TWO_PI;
		else
			wrap = z_q;
	end

	always_comb begin
		if (cmd.op == OP_EMIT_END || !cmd.first_pair)
			sum = (cmd.op == OP_EMIT_END) ? {2'b0, seg_q} + {2'b0, seg_q}
				: {2'b0, prior_seg_q} + {2'b0, seg_q};
		else
			sum = {2'b0, seg_q} + {2'b0, seg_q};
		prod   = 61'(sum) * 61'(radius_q);
		scaled = 38'((prod + 61'(1 << 22)) >> 23);
		spc    = (scaled > 38'({SPACING_W{1'b1}})) ? {SPACING_W{1'b1}} : SPACING_W'(scaled);
	end

	assign status.reduced  = (z_q < Q30_TWO_PI) && (z_q > -Q30_TWO_PI);
	assign status.eol      = eol_q;
	assign status.out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= RADIUS_RESET;
			prior_lon_q <= '0;
			prior_s_q   <= '0;
			prior_c_q   <= '0;
			prior_seg_q <= '0;
			m_tvalid    <= 1'b0;
		end else begin
			if (cfg_valid) radius_q <= cfg_data;
			if (emit_op)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			if (cmd.op == OP_COMMIT) begin
				prior_lon_q <= lon_q;
				prior_s_q   <= cur_s_q;
				prior_c_q   <= cur_c_q;
				if (cmd.pair_line) prior_seg_q <= seg_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: if (s_tvalid) begin
				lon_q <= signed'(s_tdata[31:0]);
				eol_q <= s_tlast;
				z_q   <= CW'(signed'(s_tdata[61:32])) <<< Q_SHIFT;
			end
			OP_LOAD_DLON: z_q <= (CW'(lon_q) - CW'(prior_lon_q)) <<< Q_SHIFT;
			OP_REDUCE: begin
				if (z_q >= Q30_TWO_PI)
					z_q <= z_q - Q30_TWO_PI;
				else if (z_q <= -Q30_TWO_PI)
					z_q <= z_q + Q30_TWO_PI;
			end
			OP_FOLD: begin
				x_q <= CORDIC_GAIN_INV;
				y_q <= '0;
				if (wrap > Q30_HALF_PI) begin
					z_q    <= Q30_PI - wrap;
					flip_q <= 1'b1;
				end else if (wrap < -Q30_HALF_PI) begin
					z_q    <= -Q30_PI - wrap;
					flip_q <= 1'b1;
				end else begin
					z_q    <= wrap;
					flip_q <= 1'b0;
				end
			end
			OP_ROT: begin
				if (z_q >= 0) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atn;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atn;
				end
			end
			OP_CAP_LAT: begin
				cur_s_q <= 30'(rnd(64'(y_q), 2));
				cur_c_q <= 30'(rnd(64'(x_out), 2));
			end
			OP_CAP_DLON: cd_q <= 32'(x_out);
			OP_MUL_A: p_q <= 64'(prior_c_q) * 64'(cur_c_q);
			OP_MUL_B: begin
				cc_q <= 32'(rnd(p_q, 26));
				p_q  <= 64'(prior_s_q) * 64'(cur_s_q);
			end
			OP_MUL_C: begin
				ss_q <= 32'(rnd(p_q, 26));
				p_q  <= 64'(cc_q) * 64'(cd_q);
			end
			OP_ARG: begin
				if (argsum > Q30_ONE)
					carg_q <= Q30_ONE;
				else if (argsum < -Q30_ONE)
					carg_q <= -Q30_ONE;
				else
					carg_q <= argsum;
			end
			OP_MUL_D: p_q <= 64'(carg_q) * 64'(carg_q);
			OP_SQ_INIT: begin
				sq_v_q   <= SQW'((64'sd1 <<< 60) - p_q);
				sq_r_q   <= '0;
				sq_bit_q <= SQW'(1) << 60;
			end
			OP_SQ: begin
				if (sq_v_q >= sq_try) begin
					sq_v_q <= sq_v_q - sq_try;
					sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			OP_VEC_INIT: begin
				if (carg_q < 0) begin
					x_q <= signed'(CW'(sq_r_q));
					y_q <= -carg_q;
					z_q <= Q30_HALF_PI;
				end else begin
					x_q <= carg_q;
					y_q <= signed'(CW'(sq_r_q));
					z_q <= '0;
				end
			end
			OP_VEC: begin
				if (y_q > 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atn;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atn;
				end
			end
			OP_SEG: begin
				if (z_q < 0)
					seg_q <= '0;
				else if (z_q > Q30_PI)
					seg_q <= 32'(Q30_PI);
				else
					seg_q <= 32'(z_q);
			end
			OP_EMIT_PAIR: begin
				m_tdata <= spc;
				m_tuser <= 1'b0;
				m_tlast <= 1'b0;
			end
			OP_EMIT_END: begin
				m_tdata <= spc;
				m_tuser <= 1'b0;
				m_tlast <= 1'b1;
			end
			OP_EMIT_SINGLE: begin
				m_tdata <= '0;
				m_tuser <= 1'b1;
				m_tlast <= 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/great_circle_grid_spacing.sv =====
// Top level of the great-circle grid spacing block: joins the sequencer and datapath.
// Depends on gcgs_pkg, gcgs_ctrl and gcgs_dp.
//
// Points of one grid line stream in on the slave side; for each adjacent pair the block
// forms the central angle acos(sin*sin + cos*cos*cos dlon) with one shared iterative
// CORDIC unit, and emits for each point the mean of its two neighbouring segment angles
// times the planet radius, unsigned Q32.8 metres. A point's result leaves when the next
// point arrives; the last point of a line (tlast) gives two results, the second marked by
// tlast. A one-point line gives spacing 0 with tuser set. Each point takes a CORDIC
// rotation run for its latitude; a point that follows another in its line also takes a
// rotation run for the longitude step (reduced first if wide), a handful of multiply
// steps, a bit-serial square root and a CORDIC vectoring run, plus any wait on the
// master side. The block takes one transaction at a time; a finished result waits in
// the output register.
// The radius register is written on cfg_valid and should change only while idle.
module great_circle_grid_spacing import gcgs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [63:0]          s_tdata,  // [31:0] longitude, [61:32] latitude, [63:62] zero
	input  logic                 s_tlast,  // end_of_line
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [SPACING_W-1:0] m_tdata,  // [39:0] spacing
	output logic                 m_tuser,  // single_point_line
	output logic                 m_tlast,  // line_done
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [RADIUS_W-1:0]  cfg_data
);

	cmd_t    cmd;
	status_t status;

	// Accept radius writes at any time.
	assign cfg_ready = 1'b1;

	gcgs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	gcgs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tvalid  (s_tvalid),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== tb/great_circle_grid_spacing_tb.sv =====
// Self-checking testbench for great_circle_grid_spacing: streams grid lines through the
// block and checks every spacing result against a cycle-free predictor of the arithmetic.
// Depends on gcgs_pkg and the block's RTL only.
module great_circle_grid_spacing_tb;
	import gcgs_pkg::*;

	typedef struct {
		logic signed [31:0] lon;
		logic signed [29:0] lat;
		logic               eol;
	} grid_point_t;

	typedef struct {
		logic [SPACING_W-1:0] spacing;
		logic                 single;
		logic                 done;
	} spacing_result_t;

	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint TWO_PI_Q30  = 64'sd6746518852;
	localparam longint ONE_Q30     = 64'sd1073741824;
	localparam longint GAIN_INV    = 64'sd652032874;
	localparam longint LON_MAX     = 64'sd1686629713;
	localparam longint LAT_MAX     = 64'sd421657428;
	localparam int     TURNS       = 28;
	localparam longint CYCLE_LIMIT = 64'd2000000;
	localparam int     SETTLE      = 300;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [63:0]          s_tdata = '0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [SPACING_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [RADIUS_W-1:0]  cfg_data = '0;

	great_circle_grid_spacing DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Predictor state: a private copy of everything the block remembers
	longint          radius_m;
	longint          last_lon, last_sin, last_cos;
	longint unsigned last_seg;
	int              line_pos;

	grid_point_t     points_pending[$];
	spacing_result_t spacing_due[$];
	longint unsigned cycles;
	int              points_taken, results_checked, mismatches, lines_sent, singles_seen;
	int              stall_left;
	bit              stall_done;

	longint atan_tab[32] = '{
		'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
		'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
		'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
		'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
		'h0000003F, 'h0000001F, 'h0000000F, 'h00000007, 'h00000003, 'h00000001,
		0, 0};

	// round to nearest, ties away from zero
	function automatic longint round_away(longint v, int s);
		longint half;
		half = 64'sd1 <<< (s - 1);
		if (v >= 0)
			return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	// rotation mode: sine and cosine of a Q.30 angle
	function automatic void rotate(longint z, output longint s, output longint c);
		longint r, x, y, nx;
		bit flip;
		r = z % TWO_PI_Q30;
		x = GAIN_INV;
		y = 0;
		flip = 1'b0;
		if (r > PI_Q30) r -= TWO_PI_Q30;
		if (r < -PI_Q30) r += TWO_PI_Q30;
		if (r > HALF_PI_Q30) begin
			r = PI_Q30 - r;
			flip = 1'b1;
		end else if (r < -HALF_PI_Q30) begin
			r = -PI_Q30 - r;
			flip = 1'b1;
		end
		for (int i = 0; i < TURNS; i++) begin
			if (r >= 0) begin
				nx = x - (y >>> i); y = y + (x >>> i); r -= atan_tab[i];
			end else begin
				nx = x + (y >>> i); y = y - (x >>> i); r += atan_tab[i];
			end
			x = nx;
		end
		s = y;
		c = flip ? -x : x;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b; r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// vectoring mode: central angle from its cosine, Q2.30 in [0, pi]
	function automatic longint unsigned central_angle(longint c);
		longint x, y, z, nx;
		if (c > ONE_Q30) c = ONE_Q30;
		if (c < -ONE_Q30) c = -ONE_Q30;
		x = c;
		y = longint'(int_sqrt((64'd1 << 60) - longint'(c * c)));
		z = 0;
		if (x < 0) begin
			nx = y; y = -x; x = nx; z = HALF_PI_Q30;
		end
		for (int i = 0; i < TURNS; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
			end else begin
				nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
			end
			x = nx;
		end
		if (z < 0) z = 0;
		if (z > PI_Q30) z = PI_Q30;
		return longint'(z);
	endfunction

	function automatic logic [SPACING_W-1:0] metres(longint unsigned angle_sum);
		longint unsigned v;
		v = (angle_sum * longint'(radius_m) + (64'd1 << 22)) >> 23;
		return (v > 64'hFF_FFFF_FFFF) ? '1 : v[SPACING_W-1:0];
	endfunction

	function automatic void queue_result(logic [SPACING_W-1:0] sp, logic single, logic done);
		spacing_result_t r;
		r.spacing = sp; r.single = single; r.done = done;
		spacing_due.push_back(r);
	endfunction

	// Work out what one accepted point releases and advance the line state
	function automatic void predict_spacing(grid_point_t p);
		longint lon, s30, c30, s28, c28, sd, cd, cc, ss, carg;
		longint unsigned seg;
		lon = longint'(p.lon);
		rotate(longint'(p.lat) * 4, s30, c30);
		s28 = round_away(s30, 2);
		c28 = round_away(c30, 2);
		if (line_pos == 0) begin
			if (p.eol) queue_result('0, 1'b1, 1'b1);
			else line_pos = 1;
		end else begin
			rotate((lon - last_lon) * 4, sd, cd);
			cc = round_away(last_cos * c28, 26);
			ss = round_away(last_sin * s28, 26);
			carg = ss + round_away(cc * cd, 30);
			seg = central_angle(carg);
			if (line_pos == 1) queue_result(metres(seg + seg), 1'b0, 1'b0);
			else queue_result(metres(last_seg + seg), 1'b0, 1'b0);
			if (p.eol) begin
				queue_result(metres(seg + seg), 1'b0, 1'b1);
				line_pos = 0;
			end else
				line_pos = 2;
			last_seg = seg;
		end
		last_lon = lon;
		last_sin = s28;
		last_cos = c28;
	endfunction

	function automatic void push_point(longint lon, longint lat, bit eol);
		grid_point_t p;
		p.lon = lon[31:0]; p.lat = lat[29:0]; p.eol = eol;
		points_pending.push_back(p);
	endfunction

	function automatic longint any_lon();
		return longint'($urandom_range(0, 32'd3373259426)) - LON_MAX;
	endfunction

	function automatic longint any_lat();
		return longint'($urandom_range(0, 32'd843314856)) - LAT_MAX;
	endfunction

	// Queue one grid line: mostly an evenly stepped row or column, some scattered points
	function automatic int push_line();
		int n;
		longint lon, lat, dlon, dlat;
		n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 10);
		lon = any_lon();
		lat = any_lat();
		dlon = longint'($urandom_range(0, 4000000)) - 2000000;
		dlat = longint'($urandom_range(0, 4000000)) - 2000000;
		if ($urandom_range(0, 1)) dlat = 0;
		else if ($urandom_range(0, 1)) dlon = 0;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 3) == 0) begin
				lon = any_lon(); lat = any_lat();
			end
			if (lon > LON_MAX || lon < -LON_MAX) lon = any_lon();
			if (lat > LAT_MAX || lat < -LAT_MAX) lat = any_lat();
			push_point(lon, lat, k == n - 1);
			lon += dlon; lat += dlat;
		end
		lines_sent++;
		return n;
	endfunction

	// Sender: present queued points, idling at random outside the calm stretch
	always @(posedge clk) begin
		if (arst_n) begin
			grid_point_t p;
			bit calm;
			calm = points_taken >= 600 && points_taken < 900;
			if (s_tvalid && s_tready) begin
				p.lon = s_tdata[31:0]; p.lat = s_tdata[61:32]; p.eol = s_tlast;
				predict_spacing(p);
				points_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (points_pending.size() > 0 && (calm || $urandom_range(0, 99) >= 35)) begin
					p = points_pending.pop_front();
					s_tdata <= {2'b00, p.lat, p.lon};
					s_tlast <= p.eol;
					s_tvalid <= 1'b1;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: check each result; one long hold-off lets the block back up
	always @(posedge clk) begin
		if (arst_n) begin
			spacing_result_t want;
			if (m_tvalid && m_tready) begin
				if (spacing_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: spacing %0d tuser %b tlast %b",
							m_tdata, m_tuser, m_tlast);
				end else begin
					want = spacing_due.pop_front();
					results_checked++;
					if (m_tuser) singles_seen++;
					if (m_tdata !== want.spacing || m_tuser !== want.single
							|| m_tlast !== want.done) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch on result %0d: spacing %0d/%0d tuser %b/%b tlast %b/%b (expected/actual)",
								results_checked, want.spacing, m_tdata, want.single, m_tuser,
								want.done, m_tlast);
					end
				end
			end
			if (!stall_done && points_taken >= 1200) begin
				stall_done <= 1'b1;
				stall_left <= 600;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else if (points_taken >= 600 && points_taken < 900)
				m_tready <= 1'b1;
			else
				m_tready <= $urandom_range(0, 99) >= 35;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				spacing_due.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Hold until the block has drained, then give it time to finish a silent point
	task automatic drain();
		while (points_pending.size() > 0 || s_tvalid || spacing_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_radius(longint value);
		drain();
		cfg_data <= value[RADIUS_W-1:0];
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		radius_m = value;
	endtask

	task automatic random_lines(int count);
		int n;
		n = 0;
		while (n < count) n += push_line();
	endtask

	initial begin
		cycles = 0;
		points_taken = 0; results_checked = 0; mismatches = 0;
		lines_sent = 0; singles_seen = 0; stall_left = 0; stall_done = 1'b0;
		radius_m = 6371229;
		last_lon = 0; last_sin = 0; last_cos = 0; last_seg = 0; line_pos = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one-point lines at the field extremes
		push_point(LON_MAX, LAT_MAX, 1);
		push_point(-LON_MAX, -LAT_MAX, 1);
		// extreme corners as a two-point line, then a repeated point (zero angle)
		push_point(-LON_MAX, -LAT_MAX, 0);
		push_point(LON_MAX, LAT_MAX, 1);
		push_point(12345, -6789, 0);
		push_point(12345, -6789, 1);
		// points half a turn apart on the equator: cosine argument at minus one
		push_point(0, 0, 0);
		push_point(PI_Q30 / 4, 0, 0);
		push_point(0, 0, 0);
		push_point(-LON_MAX, LAT_MAX, 1);
		// pole to pole and a longitude change beyond a full turn
		push_point(0, LAT_MAX, 0);
		push_point(LON_MAX, -LAT_MAX, 0);
		push_point(-LON_MAX, 0, 0);
		push_point(-1, -1, 1);
		lines_sent += 6;
		drain();

		write_radius((64'd1 << RADIUS_W) - 1);
		random_lines(500);
		write_radius(1);
		random_lines(300);
		write_radius(0);
		random_lines(100);
		write_radius($urandom_range(1, (1 << RADIUS_W) - 1));
		random_lines(700);
		write_radius(6371229);
		random_lines(400);
		drain();

		$display("%0d points in %0d lines, %0d results checked (%0d one-point lines)",
			points_taken, lines_sent, results_checked, singles_seen);
		$display("radius swept over default, maximum, one, zero and a random value");
		if (mismatches == 0 && spacing_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
